### hdl/cor_pkg.sv
// Package for the circle octant rasterizer: control codes, fixed widths,
// step constants and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package cor_pkg;

  localparam int unsigned DEC_W     = 14;  // decision variable width
  localparam int unsigned RADIUS_W  = 10;  // radius field width
  localparam int unsigned PIX_IDX_W = 3;   // index of the eight symmetric pixels

  localparam logic [PIX_IDX_W-1:0] PIX_LAST = 3'd7;

  // d0 = 3 - 2r
  localparam logic [DEC_W-1:0] DEC_INIT  = 14'd3;
  // Diagonal move, old x/y: 4((x+1)-(y-1))+10 = 4(x-y) + 18
  localparam logic [DEC_W-1:0] DIAG_BIAS = 14'd18;
  // Axial move, old x: 4(x+1)+6 = 4x + 10
  localparam logic [DEC_W-1:0] AXIS_BIAS = 14'd10;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cor_cmd_code_e;

  typedef struct packed {
    logic load;     // latch center/radius, seed the octant point
    logic step;     // capture point for emission, advance the octant point
    logic pix_adv;  // current word taken, move to next pixel
  } cor_cmd_t;

  typedef struct packed {
    logic pix_last;  // eighth pixel of the step is on the output
    logic finished;  // advanced point has left the octant
  } cor_status_t;

endpackage

### hdl/cor_ctrl.sv
// Controller for the circle octant rasterizer: handshake, idle/emit state
// and the drawing flag. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_ctrl
  import cor_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  cor_status_t status_i,
  output cor_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } cor_state_e;

  cor_state_e state_q, state_d;
  logic       drawing_q, drawing_d;
  logic       out_fire;
  logic       step_done;
  logic       accept;
  logic       drawing_eff;

  assign out_valid_o = (state_q == ST_EMIT);
  assign out_fire    = out_valid_o && out_ready_i;
  assign step_done   = out_fire && status_i.pix_last;
  // The next word may enter as the eighth pixel leaves.
  assign in_ready_o  = (state_q == ST_IDLE) || step_done;
  assign accept      = in_valid_i && in_ready_o;
  assign drawing_eff = drawing_q && !(step_done && status_i.finished);

  always_comb begin
    cmd_o.load    = accept && (command_i == CMD_START);
    cmd_o.step    = accept && (command_i == CMD_STEP) && drawing_eff;
    cmd_o.pix_adv = out_fire;
  end

  always_comb begin
    state_d   = state_q;
    drawing_d = drawing_eff;
    if (cmd_o.load) begin
      drawing_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.step) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (step_done && !cmd_o.step) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      drawing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      drawing_q <= drawing_d;
    end
  end

endmodule

### hdl/cor_datapath.sv
// Datapath for the circle octant rasterizer: octant point, decision
// variable, latched center, pixel index and pixel mirroring. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_datapath
  import cor_pkg::*;
#(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cor_cmd_t                     cmd_i,
  output cor_status_t                  status_o,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [RADIUS_W-1:0]   radius_i,
  output logic signed [COORD_BITS:0]   pixel_x_o,
  output logic signed [COORD_BITS:0]   pixel_y_o
);

  localparam int unsigned CALC_W = ((COORD_BITS > DEC_W) ? COORD_BITS : DEC_W) + 1;

  logic signed [COORD_BITS-1:0] ctr_x_q, ctr_y_q;
  logic signed [COORD_BITS-1:0] off_x_q, off_y_q, off_x_d, off_y_d;
  logic signed [COORD_BITS-1:0] emit_x_q, emit_y_q;
  logic        [DEC_W-1:0]      dec_q, dec_d;
  logic        [PIX_IDX_W-1:0]  idx_q;
  logic signed [CALC_W-1:0]     diff;
  logic        [DEC_W-1:0]      diag_term, axis_term;
  logic signed [COORD_BITS-1:0] mir_a, mir_b;
  logic signed [COORD_BITS:0]   ext_a, ext_b;

  // Advance from the stored point; biases fold in the post-move x/y.
  always_comb begin
    diff      = CALC_W'(off_x_q) - CALC_W'(off_y_q);
    diag_term = DEC_W'(diff) << 2;
    axis_term = DEC_W'(CALC_W'(off_x_q)) << 2;
    off_x_d   = off_x_q + COORD_BITS'(1);
    if (!dec_q[DEC_W-1]) begin
      off_y_d = off_y_q - COORD_BITS'(1);
      dec_d   = dec_q + diag_term + DIAG_BIAS;
    end else begin
      off_y_d = off_y_q;
      dec_d   = dec_q + axis_term + AXIS_BIAS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
      off_x_q  <= '0;
      off_y_q  <= '0;
      dec_q    <= '0;
      emit_x_q <= '0;
      emit_y_q <= '0;
    end else if (cmd_i.load) begin
      ctr_x_q <= center_x_i;
      ctr_y_q <= center_y_i;
      off_x_q <= '0;
      off_y_q <= COORD_BITS'(radius_i);
      dec_q   <= DEC_INIT - (DEC_W'(radius_i) << 1);
    end else if (cmd_i.step) begin
      emit_x_q <= off_x_q;
      emit_y_q <= off_y_q;
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
      dec_q    <= dec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= '0;
    end else if (cmd_i.pix_adv) begin
      idx_q <= idx_q + PIX_IDX_W'(1);
    end
  end

  // Index bit 2 swaps x/y, bit 0 negates the column term, bit 1 the row term.
  always_comb begin
    mir_a = idx_q[2] ? emit_y_q : emit_x_q;
    mir_b = idx_q[2] ? emit_x_q : emit_y_q;
    ext_a = (COORD_BITS + 1)'(mir_a);
    ext_b = (COORD_BITS + 1)'(mir_b);
    pixel_x_o = idx_q[0] ? ((COORD_BITS + 1)'(ctr_x_q) - ext_a)
                         : ((COORD_BITS + 1)'(ctr_x_q) + ext_a);
    pixel_y_o = idx_q[1] ? ((COORD_BITS + 1)'(ctr_y_q) - ext_b)
                         : ((COORD_BITS + 1)'(ctr_y_q) + ext_b);
  end

  assign status_o.pix_last = (idx_q == PIX_LAST);
  assign status_o.finished = (off_y_q < off_x_q);

endmodule

### hdl/circle_octant_rasterizer.sv
// Top level of the circle octant rasterizer: controller plus datapath.
// Depends on cor_pkg, cor_ctrl and cor_datapath.
//
// Midpoint (Bresenham) circle rasterizer. A start word (command 0) latches
// the center and radius, seeds x=0, y=r, d=3-2r and produces nothing. Each
// step word (command 1) while a circle is in progress produces the eight
// symmetric pixels of the current octant point, one per cycle on the output
// channel while the sink is ready, in the order (+x,+y) (-x,+y) (+x,-y)
// (-x,-y) (+y,+x) (-y,+x) (+y,-x) (-y,-x); duplicates are kept. last_of_step
// marks the eighth pixel, and circle_done marks the eighth pixel of the step
// that takes the point past the octant. A step word with no circle in
// progress is taken and dropped. The single output port moves one pixel word
// per cycle while the sink is ready; the next word is taken in the cycle the
// eighth pixel is taken, so back-to-back steps follow without a gap. A start
// word arriving mid circle abandons it. COORD_BITS sets the center width;
// pixels are one bit wider, and the octant point wraps at COORD_BITS bits.
`timescale 1ns / 1ps

module circle_octant_rasterizer
  import cor_pkg::*;
#(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [RADIUS_W-1:0]   radius_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS:0]   pixel_x_o,
  output logic signed [COORD_BITS:0]   pixel_y_o,
  output logic                         last_of_step_o,
  output logic                         circle_done_o
);

  cor_cmd_t    cmd;
  cor_status_t status;

  cor_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cor_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o)
  );

  // Flag the final pixel of the step and of the circle.
  assign last_of_step_o = status.pix_last;
  assign circle_done_o  = status.pix_last && status.finished;

  // A step that issues always restarts at the first pixel of the eight.
  a_step_starts_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> out_valid_o && !last_of_step_o)
    else $error("step did not restart the pixel burst");

  // Once the final pixel of a circle leaves, the output goes quiet.
  a_done_goes_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && circle_done_o |=> !out_valid_o)
    else $error("output active after circle completed");

  // A start word never produces a pixel.
  a_start_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == CMD_START) |=> !out_valid_o)
    else $error("start word produced a pixel");

endmodule

### tb/sv/tb.sv
// Self-checking bench for circle_octant_rasterizer: drives start/step words,
// predicts every pixel word in a scoreboard class and checks the output stream.
// Depends on cor_pkg and the circle_octant_rasterizer RTL.
`timescale 1ns / 1ps

module tb;
  import cor_pkg::*;

  localparam int unsigned COORD_W    = 11;
  localparam int unsigned PIX_W      = COORD_W + 1;
  localparam int          MAX_GAP    = 18;
  localparam int          RX_HOLDOFF = 300;
  localparam int          DRAIN_WAIT = 32;
  localparam int          CYCLE_CAP  = 600000;
  localparam int          ITEM_GOAL  = 260;

  typedef struct {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic                    last;
    logic                    done;
  } pixel_t;

  // Mirrors the rasterizer state and holds the pixel words still owed.
  class pixel_scoreboard;
    logic signed [COORD_W-1:0] pt_x, pt_y, org_x, org_y;
    logic signed [DEC_W-1:0]   err;
    bit                        drawing;
    pixel_t                    owed_q[$];
    int                        errors, shown, checked;
    int                        starts, steps, idle_steps, circles;

    function void note_word(cor_cmd_code_e cmd, logic signed [COORD_W-1:0] cx,
                            logic signed [COORD_W-1:0] cy, logic [RADIUS_W-1:0] r);
      int     x, y, d, ox, oy;
      int     xs[8], ys[8];
      bit     finished;
      pixel_t p;
      if (cmd == CMD_START) begin
        org_x   = cx;
        org_y   = cy;
        pt_x    = '0;
        pt_y    = COORD_W'(int'(r));
        err     = DEC_W'(3 - 2 * int'(r));
        drawing = 1'b1;
        starts++;
        return;
      end
      if (!drawing) begin
        idle_steps++;
        return;
      end
      steps++;
      ox = org_x;
      oy = org_y;
      x  = pt_x;
      y  = pt_y;
      d  = err;
      xs = '{ox + x, ox - x, ox + x, ox - x, ox + y, ox - y, ox + y, ox - y};
      ys = '{oy + y, oy + y, oy - y, oy - y, oy + x, oy + x, oy - x, oy - x};
      // Diagonal move on a non-negative decision, axial move otherwise.
      if (d >= 0) begin
        x = x + 1;
        y = y - 1;
        d = d + 4 * (x - y) + 10;
      end else begin
        x = x + 1;
        d = d + 4 * x + 6;
      end
      pt_x     = COORD_W'(x);
      pt_y     = COORD_W'(y);
      err      = DEC_W'(d);
      finished = pt_y < pt_x;
      if (finished) begin
        drawing = 1'b0;
        circles++;
      end
      for (int k = 0; k < 8; k++) begin
        p.px   = PIX_W'(xs[k]);
        p.py   = PIX_W'(ys[k]);
        p.last = (k == 7);
        p.done = (k == 7) && finished;
        owed_q.push_back(p);
      end
    endfunction

    function void check_pixel(logic signed [PIX_W-1:0] px, logic signed [PIX_W-1:0] py,
                              logic last, logic done);
      pixel_t e;
      checked++;
      if (owed_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected pixel word x=%0d y=%0d last=%0b done=%0b",
                   px, py, last, done);
        end
        return;
      end
      e = owed_q.pop_front();
      if (px !== e.px || py !== e.py || last !== e.last || done !== e.done) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                   e.px, e.py, e.last, e.done);
          $display("                got x=%0d y=%0d last=%0b done=%0b",
                   px, py, last, done);
        end
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic                        command_i    = 1'b0;
  logic signed [COORD_W-1:0]   center_x_i   = '0;
  logic signed [COORD_W-1:0]   center_y_i   = '0;
  logic        [RADIUS_W-1:0]  radius_i     = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic signed [PIX_W-1:0]     pixel_x_o;
  logic signed [PIX_W-1:0]     pixel_y_o;
  logic                        last_of_step_o;
  logic                        circle_done_o;

  pixel_scoreboard sb;
  int              words_sent;
  int              cycle_count;
  bit              tx_fast;
  bit              rx_fast;
  int              rx_hold;

  circle_octant_rasterizer #(.COORD_BITS(COORD_W)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  // Offer one word; valid stays up across back-to-back words and drops only in a gap.
  task automatic send_word(input cor_cmd_code_e cmd, input logic signed [COORD_W-1:0] cx,
                           input logic signed [COORD_W-1:0] cy,
                           input logic [RADIUS_W-1:0] r);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(cmd, cx, cy, r);
    words_sent++;
  endtask

  // Step words carry random filler in the fields the block ignores.
  task automatic send_step();
    send_word(CMD_STEP, rand_coord(), rand_coord(), RADIUS_W'($urandom));
  endtask

  // Start a circle, then either run it past the octant or cut it short.
  task automatic draw_circle(input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy,
                             input logic [RADIUS_W-1:0] r, input bit to_end,
                             input int n_steps);
    send_word(CMD_START, cx, cy, r);
    if (to_end) begin
      while (sb.drawing) send_step();
      repeat (n_steps) send_step();
    end else begin
      repeat (n_steps) send_step();
    end
  endtask

  task automatic wait_drained();
    while (sb.owed_q.size() != 0) @(posedge clk_i);
  endtask

  // Output side: draw a stall per word, honor a requested hold-off, check each word.
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end
      gap = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_pixel(pixel_x_o, pixel_y_o, last_of_step_o, circle_done_o);
    end
  end

  initial begin
    int          pick;
    int          pressure_runs;
    logic [RADIUS_W-1:0] r;
    sb            = new();
    words_sent    = 0;
    pressure_runs = 0;
    tx_fast       = 1'b0;
    rx_fast       = 1'b0;
    rx_hold       = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle step, zero radius at the corner, step after finish.
    send_step();
    draw_circle(11'sd1023, -11'sd1024, '0, 1'b1, 1);
    // Largest radius at opposite corners for extreme pixels, then abandon.
    draw_circle(-11'sd1024, 11'sd1023, 10'd1023, 1'b0, 3);
    draw_circle(11'sd0, 11'sd0, 10'd1, 1'b1, 1);
    draw_circle(11'sd1023, 11'sd1023, 10'd1023, 1'b0, 2);
    draw_circle(-11'sd1024, -11'sd1024, 10'd1023, 1'b0, 2);
    draw_circle(11'sd5, -11'sd7, 10'd5, 1'b1, 0);
    wait_drained();

    // Random circles: mostly small and finished, some large and cut short.
    while (words_sent < ITEM_GOAL) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 7) begin
        r = RADIUS_W'($urandom_range(0, 24));
        draw_circle(rand_coord(), rand_coord(), r, 1'b1, $urandom_range(0, 2));
      end else if (pick < 8) begin
        r = RADIUS_W'($urandom_range(0, 60));
        draw_circle(rand_coord(), rand_coord(), r, 1'b0, $urandom_range(0, 6));
      end else begin
        r = RADIUS_W'($urandom);
        draw_circle(rand_coord(), rand_coord(), r, 1'b0, $urandom_range(0, 5));
      end
      if (words_sent > ITEM_GOAL / 3 && (pressure_runs == 0 || sb.circles % 7 == 3)) begin
        // Hold the sink while the source streams steps, so the block backs up.
        pressure_runs++;
        tx_fast = 1'b1;
        rx_hold = RX_HOLDOFF;
        draw_circle(rand_coord(), rand_coord(), 10'd20, 1'b1, 0);
        // Then let everything owed come out before offering more.
        wait_drained();
      end
    end

    in_valid_i <= 1'b0;
    rx_fast = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d start and %0d step words (%0d while idle), %0d circles completed.",
             sb.starts, sb.steps + sb.idle_steps, sb.idle_steps, sb.circles);
    $display("Checked %0d pixel words, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
